@@ rtl/core/p3ik_pkg.sv @@
// ----------------------------------------------------------------------------
// p3ik_pkg
// Shared widths, angle constants and arctangent table for the planar
// three-link inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package p3ik_pkg;

	// CORDIC iterations per rotation/vectoring unit (8..24)
	localparam int CORDIC_STAGES = 16;

	// Link length registers
	localparam int LEN_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_THREE = 2'd2;
	localparam logic [LEN_W-1:0] LINK_ONE_RST   = 15'd5120;
	localparam logic [LEN_W-1:0] LINK_TWO_RST   = 15'd4096;
	localparam logic [LEN_W-1:0] LINK_THREE_RST = 15'd1024;

	// Internal widths
	localparam int ANG_W = 28;  // degrees, 16 fraction bits
	localparam int ROT_W = 33;  // sine/cosine, 30 fraction bits plus gain
	localparam int WX_W  = 24;  // wrist coordinates, 16 fraction bits
	localparam int NUM_W = 49;  // acos numerator
	localparam int DEN_W = 44;  // acos denominator
	localparam int REM_W = 45;  // divider remainder
	localparam int Q_W   = 31;  // acos argument magnitude, 30 fraction bits
	localparam int C2_W  = 32;  // signed acos argument
	localparam int SQ_W  = 61;  // radicand
	localparam int RES_W = 62;  // square root partial result
	localparam int S2_W  = 31;  // sine of theta2
	localparam int AT_W  = 50;  // vectoring CORDIC datapath
	localparam int K_W   = 6;   // normalising shift amount

	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 31;
	localparam int NORM_BIT   = 44;
	localparam int ATAN_LAT   = 4 + CORDIC_STAGES;
	localparam int TOTAL_STAGES = 79 + 2 * CORDIC_STAGES;

	localparam logic signed [ANG_W-1:0] DEG_HALF    = 28'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG_FULL    = 28'sd23592960;
	localparam logic signed [ANG_W-1:0] DEG_QUARTER = 28'sd5898240;
	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// atan(2^-i) in degrees, 16 fraction bits
	localparam logic signed [ANG_W-1:0] ATAN_TAB [0:23] = '{
		28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
		28'sd234379,  28'sd117304,  28'sd58666,  28'sd29335,
		28'sd14668,   28'sd7334,    28'sd3667,   28'sd1833,
		28'sd917,     28'sd458,     28'sd229,    28'sd115,
		28'sd57,      28'sd29,      28'sd14,     28'sd7,
		28'sd4,       28'sd2,       28'sd1,      28'sd0
	};

endpackage

@@ rtl/core/p3ik_atan.sv @@
// ----------------------------------------------------------------------------
// p3ik_atan
// Pipelined atan(num/den) in degrees: sign fold, normalising shift and a
// vectoring CORDIC. Advances when en is high.
// ----------------------------------------------------------------------------
module p3ik_atan
	import p3ik_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AT_W-1:0]  num,
	input  logic signed [AT_W-1:0]  den,
	output logic signed [ANG_W-1:0] angle
);

	localparam int CS = CORDIC_STAGES;

	logic signed [AT_W-1:0] d_s1, n_s1, d_s2, n_s2, d_s3, n_s3;
	logic                   zero_s1, zero_s2, zero_s3;
	logic        [AT_W-1:0] mag_s2;
	logic        [K_W-1:0]  k_s3;

	logic signed [AT_W-1:0]  vx_s [0:CS];
	logic signed [AT_W-1:0]  vy_s [0:CS];
	logic signed [ANG_W-1:0] vz_s [0:CS];
	logic                    vzero_s [0:CS];

	logic        [AT_W-1:0] nabs;
	logic        [K_W-1:0]  k_c;

	// fold a negative denominator into the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= (den < 0) ? -den : den;
			n_s1    <= (den < 0) ? -num : num;
			zero_s1 <= (num == '0) && (den == '0);
		end
	end

	assign nabs = (n_s1 < 0) ? AT_W'(-n_s1) : AT_W'(n_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2    <= d_s1;
			n_s2    <= n_s1;
			zero_s2 <= zero_s1;
			mag_s2  <= (AT_W'(d_s1) > nabs) ? AT_W'(d_s1) : nabs;
		end
	end

	// leading one search: shift the larger operand up to bit NORM_BIT
	always_comb begin
		k_c = K_W'(NORM_BIT);
		for (int b = 0; b < NORM_BIT; b++) begin
			if (mag_s2[b]) k_c = K_W'(NORM_BIT - b);
		end
		if (mag_s2 >= (AT_W'(1) << NORM_BIT)) k_c = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3    <= d_s2;
			n_s3    <= n_s2;
			zero_s3 <= zero_s2;
			k_s3    <= k_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0]    <= d_s3 <<< k_s3;
			vy_s[0]    <= n_s3 <<< k_s3;
			vz_s[0]    <= '0;
			vzero_s[0] <= zero_s3;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_s[i] >= 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + ATAN_TAB[i];
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - ATAN_TAB[i];
				end
				vzero_s[i+1] <= vzero_s[i];
			end
		end
	end

	assign angle = vzero_s[CS] ? '0 : vz_s[CS];

endmodule

@@ rtl/core/planar_three_link_inverse_kinematics_unit.sv @@
// ----------------------------------------------------------------------------
// planar_three_link_inverse_kinematics_unit
// Elbow solution of a planar three-link arm from one end-effector pose.
// A pose (x, y in signed Q5.10, orientation in Q9.6 degrees) goes in, the
// three joint angles (one and three in Q9.6 degrees, two in unsigned Q8.6)
// and an unreachable flag come out. The block is one fully pipelined datapath
// of 79 + 2*CORDIC_STAGES registers (111 with 16 CORDIC stages): a rotation
// CORDIC for the wrist offset, the squared reach, a 31-step restoring
// divider for cos theta2, a 31-step square root for sin theta2, three
// parallel vectoring CORDICs for the arctangents and a rounding stage. A new
// pose is taken every clock cycle while in_ready is high. Output back-pressure
// freezes the whole pipeline only once a skid word behind the output
// register is full, so a result waiting at the output does not block the
// input. Link lengths are written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty. A zero first or second link,
// a wrist on the x axis or a pose out of reach raise unreachable, zero angles.
// ----------------------------------------------------------------------------
module planar_three_link_inverse_kinematics_unit
	import p3ik_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   target_x,
	input  logic signed [15:0]   target_y,
	input  logic signed [15:0]   orientation,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   joint_one_angle,
	output logic        [13:0]   joint_two_angle,
	output logic signed [15:0]   joint_three_angle,
	output logic                 unreachable
);

	localparam int CS = CORDIC_STAGES;

	// ---------------------------------------------------------------- config
	logic [LEN_W-1:0] link_one_q, link_two_q, link_three_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_one_q   <= LINK_ONE_RST;
			link_two_q   <= LINK_TWO_RST;
			link_three_q <= LINK_THREE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINK_ONE:   link_one_q   <= cfg_data;
				CFG_LINK_TWO:   link_two_q   <= cfg_data;
				CFG_LINK_THREE: link_three_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// --------------------------------------------------------- flow control
	// The whole pipeline advances together; it only holds when the skid
	// word is occupied.
	logic                    en;
	logic [TOTAL_STAGES:1]   vld_q;
	logic                    skid_vld_q, out_vld_q;

	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[TOTAL_STAGES-1:1], in_valid};
	end

	// ------------------------------------------------ rotation CORDIC (sin/cos)
	logic signed [ANG_W-1:0] ang_raw, ang_wrap, ang_fold;
	logic                    ang_flip;

	// wrap into -180..180, then fold into -90..90 and flip the result
	always_comb begin
		ang_raw  = {{(ANG_W-26){orientation[15]}}, orientation, 10'd0};
		ang_wrap = ang_raw;
		if (ang_raw >= DEG_HALF) ang_wrap = ang_raw - DEG_FULL;
		else if (ang_raw < -DEG_HALF) ang_wrap = ang_raw + DEG_FULL;
		ang_fold = ang_wrap;
		ang_flip = 1'b0;
		if (ang_wrap > DEG_QUARTER) begin
			ang_fold = ang_wrap - DEG_HALF;
			ang_flip = 1'b1;
		end else if (ang_wrap < -DEG_QUARTER) begin
			ang_fold = ang_wrap + DEG_HALF;
			ang_flip = 1'b1;
		end
	end

	logic signed [ROT_W-1:0] rx_s [0:CS];
	logic signed [ROT_W-1:0] ry_s [0:CS];
	logic signed [ANG_W-1:0] ra_s [0:CS];
	logic                    rflip_s [0:CS];
	logic signed [15:0]      rtx_s [0:CS];
	logic signed [15:0]      rty_s [0:CS];
	logic signed [15:0]      rori_s [0:CS];

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]    <= CORDIC_GAIN;
			ry_s[0]    <= '0;
			ra_s[0]    <= ang_fold;
			rflip_s[0] <= ang_flip;
			rtx_s[0]   <= target_x;
			rty_s[0]   <= target_y;
			rori_s[0]  <= orientation;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (ra_s[i] >= 0) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					ra_s[i+1] <= ra_s[i] - ATAN_TAB[i];
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					ra_s[i+1] <= ra_s[i] + ATAN_TAB[i];
				end
				rflip_s[i+1] <= rflip_s[i];
				rtx_s[i+1]   <= rtx_s[i];
				rty_s[i+1]   <= rty_s[i];
				rori_s[i+1]  <= rori_s[i];
			end
		end
	end

	// ---------------------------------------------------------- wrist point
	logic signed [ROT_W-1:0] co_c, si_c;
	logic signed [48:0]      pc_s1, ps_s1;
	logic signed [15:0]      wtx_s1, wty_s1, wori_s1;

	assign co_c = rflip_s[CS] ? -rx_s[CS] : rx_s[CS];
	assign si_c = rflip_s[CS] ? -ry_s[CS] : ry_s[CS];

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1   <= $signed({1'b0, link_three_q}) * co_c;
			ps_s1   <= $signed({1'b0, link_three_q}) * si_c;
			wtx_s1  <= rtx_s[CS];
			wty_s1  <= rty_s[CS];
			wori_s1 <= rori_s[CS];
		end
	end

	// round l3*cos and l3*sin half up to 16 fraction bits, subtract from target
	logic signed [48:0]     wxl_c, wyl_c;
	logic signed [WX_W-1:0] wx_s2, wy_s2;
	logic signed [15:0]     wori_s2;

	assign wxl_c = $signed({{27{wtx_s1[15]}}, wtx_s1, 6'd0})
		- ((pc_s1 + 49'sd8388608) >>> 24);
	assign wyl_c = $signed({{27{wty_s1[15]}}, wty_s1, 6'd0})
		- ((ps_s1 + 49'sd8388608) >>> 24);

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s2   <= wxl_c[WX_W-1:0];
			wy_s2   <= wyl_c[WX_W-1:0];
			wori_s2 <= wori_s1;
		end
	end

	// squares of the wrist coordinates and of the links
	logic signed [47:0]     sqx_s3, sqy_s3;
	logic        [29:0]     ll1_s3, ll2_s3, l12_s3;
	logic signed [WX_W-1:0] wx_s3, wy_s3;
	logic signed [15:0]     wori_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3  <= wx_s2 * wx_s2;
			sqy_s3  <= wy_s2 * wy_s2;
			ll1_s3  <= link_one_q * link_one_q;
			ll2_s3  <= link_two_q * link_two_q;
			l12_s3  <= link_one_q * link_two_q;
			wx_s3   <= wx_s2;
			wy_s3   <= wy_s2;
			wori_s3 <= wori_s2;
		end
	end

	// acos numerator and denominator
	logic signed [NUM_W-1:0] num_s4;
	logic        [DEN_W-1:0] den_s4;
	logic                    wyz_s4;
	logic signed [WX_W-1:0]  wx_s4, wy_s4;
	logic signed [15:0]      wori_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= NUM_W'(sqx_s3) + NUM_W'(sqy_s3)
				- $signed({7'd0, ll1_s3, 12'd0}) - $signed({7'd0, ll2_s3, 12'd0});
			den_s4  <= {1'b0, l12_s3, 13'd0};
			wyz_s4  <= (wy_s3 == '0);
			wx_s4   <= wx_s3;
			wy_s4   <= wy_s3;
			wori_s4 <= wori_s3;
		end
	end

	// reach check; the divider takes the magnitude
	logic signed [NUM_W-1:0] den_sx;
	logic signed [NUM_W-1:0] nabs_c;
	logic                    flag_c;

	assign den_sx = $signed({{(NUM_W-DEN_W){1'b0}}, den_s4});
	assign nabs_c = (num_s4 < 0) ? -num_s4 : num_s4;
	assign flag_c = (den_s4 == '0) || wyz_s4 || (num_s4 > den_sx) || (-num_s4 > den_sx);

	// ---------------------------------------------------- restoring divider
	logic [REM_W-1:0]        dr_s [0:DIV_STEPS];
	logic [Q_W-1:0]          dq_s [0:DIV_STEPS];
	logic [DEN_W-1:0]        dd_s [0:DIV_STEPS];
	logic                    dflag_s [0:DIV_STEPS];
	logic                    dneg_s [0:DIV_STEPS];
	logic signed [WX_W-1:0]  dwx_s [0:DIV_STEPS];
	logic signed [WX_W-1:0]  dwy_s [0:DIV_STEPS];
	logic signed [15:0]      dori_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s[0]    <= nabs_c[REM_W-1:0];
			dq_s[0]    <= '0;
			dd_s[0]    <= den_s4;
			dflag_s[0] <= flag_c;
			dneg_s[0]  <= (num_s4 < 0);
			dwx_s[0]   <= wx_s4;
			dwy_s[0]   <= wy_s4;
			dori_s[0]  <= wori_s4;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [REM_W-1:0] rt;
		logic             ge;
		// the first step compares without a shift
		assign rt = (j == 0) ? dr_s[j] : {dr_s[j][REM_W-2:0], 1'b0};
		assign ge = (rt >= {1'b0, dd_s[j]});
		always_ff @(posedge clk) begin
			if (en) begin
				dr_s[j+1]    <= ge ? (rt - {1'b0, dd_s[j]}) : rt;
				dq_s[j+1]    <= {dq_s[j][Q_W-2:0], ge};
				dd_s[j+1]    <= dd_s[j];
				dflag_s[j+1] <= dflag_s[j];
				dneg_s[j+1]  <= dneg_s[j];
				dwx_s[j+1]   <= dwx_s[j];
				dwy_s[j+1]   <= dwy_s[j];
				dori_s[j+1]  <= dori_s[j];
			end
		end
	end

	// ----------------------------------------------------- 1 - c^2, sqrt
	logic signed [C2_W-1:0] c2_e1;
	logic        [61:0]     qsq_e1;
	logic                   flag_e1;
	logic signed [WX_W-1:0] wx_e1, wy_e1;
	logic signed [15:0]     ori_e1;

	always_ff @(posedge clk) begin
		if (en) begin
			c2_e1   <= dneg_s[DIV_STEPS] ? -$signed({1'b0, dq_s[DIV_STEPS]})
				: $signed({1'b0, dq_s[DIV_STEPS]});
			qsq_e1  <= dq_s[DIV_STEPS] * dq_s[DIV_STEPS];
			flag_e1 <= dflag_s[DIV_STEPS];
			wx_e1   <= dwx_s[DIV_STEPS];
			wy_e1   <= dwy_s[DIV_STEPS];
			ori_e1  <= dori_s[DIV_STEPS];
		end
	end

	logic [61:0] rad_c;
	assign rad_c = (62'd1 << 60) - qsq_e1;

	logic [SQ_W-1:0]        sv_s [0:SQRT_STEPS];
	logic [RES_W-1:0]       sr_s [0:SQRT_STEPS];
	logic                   sflag_s [0:SQRT_STEPS];
	logic signed [C2_W-1:0] sc2_s [0:SQRT_STEPS];
	logic signed [WX_W-1:0] swx_s [0:SQRT_STEPS];
	logic signed [WX_W-1:0] swy_s [0:SQRT_STEPS];
	logic signed [15:0]     sori_s [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[0]    <= rad_c[SQ_W-1:0];
			sr_s[0]    <= '0;
			sflag_s[0] <= flag_e1;
			sc2_s[0]   <= c2_e1;
			swx_s[0]   <= wx_e1;
			swy_s[0]   <= wy_e1;
			sori_s[0]  <= ori_e1;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [RES_W-1:0] BIT = RES_W'(1) << (60 - 2 * j);
		logic [RES_W:0] ts;
		logic           ge;
		assign ts = {1'b0, sr_s[j]} + {1'b0, BIT};
		assign ge = ({{(RES_W+1-SQ_W){1'b0}}, sv_s[j]} >= ts);
		always_ff @(posedge clk) begin
			if (en) begin
				sv_s[j+1]    <= ge ? (sv_s[j] - ts[SQ_W-1:0]) : sv_s[j];
				sr_s[j+1]    <= ge ? ((sr_s[j] >> 1) + BIT) : (sr_s[j] >> 1);
				sflag_s[j+1] <= sflag_s[j];
				sc2_s[j+1]   <= sc2_s[j];
				swx_s[j+1]   <= swx_s[j];
				swy_s[j+1]   <= swy_s[j];
				sori_s[j+1]  <= sori_s[j];
			end
		end
	end

	// ------------------------------------------------- arctangent operands
	logic [S2_W-1:0]        s2_c;
	assign s2_c = sr_s[SQRT_STEPS][S2_W-1:0];

	logic [45:0]            m1_p1;
	logic signed [47:0]     m2_p1;
	logic [S2_W-1:0]        s2_p1;
	logic signed [C2_W-1:0] c2_p1;
	logic signed [WX_W-1:0] wx_p1, wy_p1;
	logic                   flag_p1;
	logic signed [15:0]     ori_p1;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_p1   <= link_two_q * s2_c;
			m2_p1   <= $signed({1'b0, link_two_q}) * sc2_s[SQRT_STEPS];
			s2_p1   <= s2_c;
			c2_p1   <= sc2_s[SQRT_STEPS];
			wx_p1   <= swx_s[SQRT_STEPS];
			wy_p1   <= swy_s[SQRT_STEPS];
			flag_p1 <= sflag_s[SQRT_STEPS];
			ori_p1  <= sori_s[SQRT_STEPS];
		end
	end

	logic signed [AT_W-1:0] an_p2, ad_p2, bn_p2, bd_p2, cn_p2, cd_p2;

	always_ff @(posedge clk) begin
		if (en) begin
			an_p2 <= AT_W'(wx_p1);
			ad_p2 <= AT_W'(wy_p1);
			bn_p2 <= $signed({{(AT_W-S2_W){1'b0}}, s2_p1});
			bd_p2 <= (c2_p1 < 0) ? -AT_W'(c2_p1) : AT_W'(c2_p1);
			cn_p2 <= $signed({{(AT_W-46){1'b0}}, m1_p1});
			cd_p2 <= $signed({5'd0, link_one_q, 30'd0}) + AT_W'(m2_p1);
		end
	end

	// sideband that rides alongside the arctangent units
	logic                tflag_s [0:ATAN_LAT];
	logic                tneg_s  [0:ATAN_LAT];
	logic signed [15:0]  tori_s  [0:ATAN_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			tflag_s[0] <= flag_p1;
			tneg_s[0]  <= (c2_p1 < 0);
			tori_s[0]  <= ori_p1;
		end
	end

	for (genvar t = 0; t < ATAN_LAT; t++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				tflag_s[t+1] <= tflag_s[t];
				tneg_s[t+1]  <= tneg_s[t];
				tori_s[t+1]  <= tori_s[t];
			end
		end
	end

	logic signed [ANG_W-1:0] za, zb, zc;

	// wrist direction, elbow angle, and shoulder correction
	p3ik_atan u_atan_wrist (.clk(clk), .en(en), .num(an_p2), .den(ad_p2), .angle(za));
	p3ik_atan u_atan_elbow (.clk(clk), .en(en), .num(bn_p2), .den(bd_p2), .angle(zb));
	p3ik_atan u_atan_corr  (.clk(clk), .en(en), .num(cn_p2), .den(cd_p2), .angle(zc));

	// ------------------------------------------------------- joint angles
	logic signed [ANG_W-1:0] th2raw_c, th2cl_c;

	always_comb begin
		th2raw_c = tneg_s[ATAN_LAT] ? (DEG_HALF - zb) : zb;
		th2cl_c  = th2raw_c;
		if (th2raw_c < 0) th2cl_c = '0;
		else if (th2raw_c > DEG_HALF) th2cl_c = DEG_HALF;
	end

	logic signed [ANG_W-1:0] th1_f1, th2_f1;
	logic                    flag_f1;
	logic signed [15:0]      ori_f1;

	always_ff @(posedge clk) begin
		if (en) begin
			th1_f1  <= za - zc;
			th2_f1  <= th2cl_c;
			flag_f1 <= tflag_s[ATAN_LAT];
			ori_f1  <= tori_s[ATAN_LAT];
		end
	end

	logic signed [ANG_W-1:0] th1_f2, th2_f2, th3_f2;
	logic                    flag_f2;

	always_ff @(posedge clk) begin
		if (en) begin
			th1_f2  <= th1_f1;
			th2_f2  <= th2_f1;
			th3_f2  <= $signed({{(ANG_W-26){ori_f1[15]}}, ori_f1, 10'd0}) - th1_f1 - th2_f1;
			flag_f2 <= flag_f1;
		end
	end

	// round half up to Q9.6 and saturate
	logic signed [ANG_W-1:0] r1_c, r2_c, r3_c;
	logic signed [15:0]      j1_c, j3_c;
	logic        [13:0]      j2_c;

	always_comb begin
		r1_c = (th1_f2 + ANG_W'(512)) >>> 10;
		r2_c = (th2_f2 + ANG_W'(512)) >>> 10;
		r3_c = (th3_f2 + ANG_W'(512)) >>> 10;
		j1_c = r1_c[15:0];
		if (r1_c < -ANG_W'(32768)) j1_c = 16'sh8000;
		else if (r1_c > ANG_W'(32767)) j1_c = 16'sh7FFF;
		j3_c = r3_c[15:0];
		if (r3_c < -ANG_W'(32768)) j3_c = 16'sh8000;
		else if (r3_c > ANG_W'(32767)) j3_c = 16'sh7FFF;
		j2_c = r2_c[13:0];
		if (r2_c < 0) j2_c = '0;
		else if (r2_c > ANG_W'(11520)) j2_c = 14'd11520;
	end

	logic signed [15:0] j1_f3, j3_f3;
	logic        [13:0] j2_f3;
	logic               flag_f3;

	always_ff @(posedge clk) begin
		if (en) begin
			j1_f3   <= flag_f2 ? '0 : j1_c;
			j2_f3   <= flag_f2 ? '0 : j2_c;
			j3_f3   <= flag_f2 ? '0 : j3_c;
			flag_f3 <= flag_f2;
		end
	end

	// ------------------------------------------------ output and skid word
	logic signed [15:0] j1_q, j3_q, sk_j1_q, sk_j3_q;
	logic        [13:0] j2_q, sk_j2_q;
	logic               flag_q, sk_flag_q;
	logic               out_free;

	assign out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			// drain the skid word first, else take the pipeline head
			out_vld_q  <= skid_vld_q || (en && vld_q[TOTAL_STAGES]);
			skid_vld_q <= 1'b0;
		end else if (en && vld_q[TOTAL_STAGES]) begin
			// output held: park the word leaving the pipeline
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			j1_q   <= skid_vld_q ? sk_j1_q : j1_f3;
			j2_q   <= skid_vld_q ? sk_j2_q : j2_f3;
			j3_q   <= skid_vld_q ? sk_j3_q : j3_f3;
			flag_q <= skid_vld_q ? sk_flag_q : flag_f3;
		end
		if (!out_free && en) begin
			sk_j1_q   <= j1_f3;
			sk_j2_q   <= j2_f3;
			sk_j3_q   <= j3_f3;
			sk_flag_q <= flag_f3;
		end
	end

	assign out_valid         = out_vld_q;
	assign joint_one_angle   = j1_q;
	assign joint_two_angle   = j2_q;
	assign joint_three_angle = j3_q;
	assign unreachable       = flag_q;

	// ------------------------------------------------------------ checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held while output register empty");

	a_flag_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && flag_q) |-> (j1_q == '0 && j2_q == '0 && j3_q == '0))
		else $error("unreachable word carries non-zero angles");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (j2_q <= 14'd11520))
		else $error("elbow angle beyond 180 degrees");

endmodule

@@ tb/planar_three_link_inverse_kinematics_unit_test.sv @@
// ----------------------------------------------------------------------------
// planar_three_link_inverse_kinematics_unit_test
// Drives poses into the inverse kinematics pipeline under random idling and
// back-pressure, works out every joint word with a bit-exact fixed point
// predictor and compares each output word, field by field, in order.
// ----------------------------------------------------------------------------
module planar_three_link_inverse_kinematics_unit_test
	import p3ik_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it, written to check it is ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam longint ONE_DEG = 65536;
	localparam longint NORM_LIMIT = longint'(1) << 44;
	localparam int DRAIN_CYCLES = TOTAL_STAGES + 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [15:0] j1;
		logic        [13:0] j2;
		logic signed [15:0] j3;
		logic               flag;
	} joint_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LINK_ONE;
	logic [LEN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] target_x = '0;
	logic signed [15:0] target_y = '0;
	logic signed [15:0] orientation = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] joint_one_angle;
	logic        [13:0] joint_two_angle;
	logic signed [15:0] joint_three_angle;
	logic unreachable;

	// predictor copy of the link registers
	longint link_one = 5120, link_two = 4096, link_three = 1024;
	joint_word_t joints_pending[$];
	int errors = 0;
	int cycle_count = 0;
	bit steady = 1'b0;       // no idling on either side while set
	int hold_len = 0;        // cycles the receiver still holds off

	planar_three_link_inverse_kinematics_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Guard against a hung pipeline.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random idling, long hold-offs when asked for.
	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len <= hold_len - 1;
		end else if (steady)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 99) >= 28);
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	// Compare every accepted output word with the oldest pending one.
	always @(posedge clk) begin
		joint_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (joints_pending.size() == 0)
				report_mismatch("unexpected word", 1, 0);
			else begin
				w = joints_pending.pop_front();
				if (joint_one_angle !== w.j1)
					report_mismatch("joint_one", longint'(joint_one_angle), longint'(w.j1));
				if (joint_two_angle !== w.j2)
					report_mismatch("joint_two", longint'(joint_two_angle), longint'(w.j2));
				if (joint_three_angle !== w.j3)
					report_mismatch("joint_three", longint'(joint_three_angle),
						longint'(w.j3));
				if (unreachable !== w.flag)
					report_mismatch("unreachable", longint'(unreachable), longint'(w.flag));
			end
		end
	end

	// Rotation CORDIC: cosine and sine with 30 fraction bits plus gain.
	task automatic rotate_unit(input longint a, output longint co, output longint si);
		longint x, y, nx, ny;
		bit flip;
		x = 652032874; y = 0; flip = 0;
		while (a >= 180 * ONE_DEG) a -= 360 * ONE_DEG;
		while (a < -180 * ONE_DEG) a += 360 * ONE_DEG;
		if (a > 90 * ONE_DEG) begin
			a -= 180 * ONE_DEG; flip = 1;
		end else if (a < -90 * ONE_DEG) begin
			a += 180 * ONE_DEG; flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); a -= ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); a += ATAN_TAB[i];
			end
			x = nx; y = ny;
		end
		co = flip ? -x : x;
		si = flip ? -y : y;
	endtask

	// Vectoring CORDIC: atan(num/den) in degrees, 16 fraction bits.
	function automatic longint atan_of(input longint num, input longint den);
		longint z, nx, ny;
		z = 0;
		if (den < 0) begin
			den = -den; num = -num;
		end
		if (num == 0 && den == 0) return 0;
		for (int k = 0; k < 64; k++) begin
			if (den >= NORM_LIMIT || num >= NORM_LIMIT || num <= -NORM_LIMIT) break;
			den *= 2; num *= 2;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			if (num >= 0) begin
				nx = den + (num >>> i); ny = num - (den >>> i); z += ATAN_TAB[i];
			end else begin
				nx = den - (num >>> i); ny = num + (den >>> i); z -= ATAN_TAB[i];
			end
			den = nx; num = ny;
		end
		return z;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b; res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint round_q96(input longint v, input longint lo, input longint hi);
		longint r;
		r = (v + 512) >>> 10;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	// Joint angles of one pose under the current link lengths.
	task automatic solve_pose(input logic signed [15:0] tx, input logic signed [15:0] ty,
			input logic signed [15:0] o, output joint_word_t w);
		longint ori, co, si, wx, wy, num, den, c2, th1, th2, th3;
		longint unsigned rem, dv, q, s2;
		ori = longint'(o) * 1024;
		rotate_unit(ori, co, si);
		wx = longint'(tx) * 64 - ((link_three * co + (longint'(1) << 23)) >>> 24);
		wy = longint'(ty) * 64 - ((link_three * si + (longint'(1) << 23)) >>> 24);
		num = wx * wx + wy * wy - link_one * link_one * 4096 - link_two * link_two * 4096;
		den = 2 * link_one * link_two * 4096;
		if (den == 0 || wy == 0 || num > den || -num > den) begin
			w.j1 = '0; w.j2 = '0; w.j3 = '0; w.flag = 1'b1;
			return;
		end
		rem = (num < 0) ? -num : num;
		dv = den;
		q = 0;
		if (rem >= dv) begin
			q = 1; rem -= dv;
		end
		for (int i = 0; i < 30; i++) begin
			rem <<= 1; q <<= 1;
			if (rem >= dv) begin
				rem -= dv; q |= 1;
			end
		end
		c2 = (num < 0) ? -longint'(q) : longint'(q);
		s2 = floor_sqrt((64'd1 << 60) - longint'(c2 * c2));
		if (c2 < 0) th2 = 180 * ONE_DEG - atan_of(longint'(s2), -c2);
		else th2 = atan_of(longint'(s2), c2);
		if (th2 < 0) th2 = 0;
		if (th2 > 180 * ONE_DEG) th2 = 180 * ONE_DEG;
		th1 = atan_of(wx, wy) -
			atan_of(link_two * longint'(s2), link_one * (longint'(1) << 30) + link_two * c2);
		th3 = ori - th1 - th2;
		w.j1 = 16'(round_q96(th1, -32768, 32767));
		w.j2 = 14'(round_q96(th2, 0, 11520));
		w.j3 = 16'(round_q96(th3, -32768, 32767));
		w.flag = 1'b0;
	endtask

	// Offer one pose, hold it until taken, then queue its joint word.
	task automatic send_pose(input logic signed [15:0] tx, input logic signed [15:0] ty,
			input logic signed [15:0] o);
		joint_word_t w;
		while (!steady && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		orientation <= o;
		do @(posedge clk); while (!in_ready);
		solve_pose(tx, ty, o, w);
		joints_pending.push_back(w);
	endtask

	// Stop offering, let every pending word out, then let the pipe empty.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (joints_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one link register; only called with the pipeline empty.
	// Drop cfg_we again after the write so back-to-back writes stay apart.
	task automatic write_link(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_LINK_ONE: link_one = longint'(val);
			CFG_LINK_TWO: link_two = longint'(val);
			CFG_LINK_THREE: link_three = longint'(val);
			default: ;
		endcase
	endtask

	function automatic logic signed [15:0] any_angle();
		return $signed(16'($urandom_range(0, 46080))) - 16'sd23040;
	endfunction

	// Pose near the arm's reach; most land inside the workspace.
	task automatic send_reachable();
		int span;
		span = int'(link_one + link_two + link_three) + 256;
		if (span > 32767) span = 32767;
		send_pose(16'($urandom_range(0, 2 * span) - span),
			16'($urandom_range(0, 2 * span) - span), any_angle());
	endtask

	task automatic test_directed();
		// extremes of position and orientation, wrap beyond a half turn
		send_pose(16'sh7fff, 16'sh7fff, 16'sd23040);
		send_pose(16'sh8000, 16'sh8000, -16'sd23040);
		send_pose(16'sh7fff, 16'sh8000, 16'sd0);
		send_pose(16'sd0, 16'sd0, 16'sd0);
		// wrist on the x axis: y cancels the end link exactly at zero angle
		send_pose(16'sd6144, 16'sd0, 16'sd0);
		send_pose(16'sd4096, 16'sd0, 16'sd0);
		// reachable poses around the workspace, both signs
		send_pose(16'sd5120, 16'sd5120, 16'sd2880);
		send_pose(-16'sd5120, 16'sd4096, 16'sd5760);
		send_pose(16'sd3072, -16'sd6144, -16'sd5760);
		send_pose(-16'sd2048, -16'sd3072, 16'sd11520);
		send_pose(16'sd9216, 16'sd1024, -16'sd11520);
		send_pose(16'sd1024, 16'sd2048, 16'sd17280);
		// fully stretched and fully folded
		send_pose(16'sd0, 16'sd10240, 16'sd5760);
		send_pose(16'sd0, 16'sd2048, 16'sd5760);
		// out of reach
		send_pose(16'sd20000, 16'sd20000, 16'sd100);
		send_pose(16'sd1, 16'sd1, -16'sd1);
		drain_pipe();
	endtask

	task automatic test_link_settings();
		// zero first link, then zero second link, both raise the flag
		write_link(CFG_LINK_ONE, 15'd0);
		send_pose(16'sd2048, 16'sd4096, 16'sd0);
		drain_pipe();
		write_link(CFG_LINK_ONE, 15'd1);
		write_link(CFG_LINK_TWO, 15'd0);
		send_pose(16'sd2048, 16'sd4096, 16'sd0);
		drain_pipe();
		// smallest links, no end link
		write_link(CFG_LINK_TWO, 15'd1);
		write_link(CFG_LINK_THREE, 15'd0);
		repeat (20) send_reachable();
		send_pose(16'sd0, 16'sd1, 16'sd0);
		drain_pipe();
		// top of range, then above range as written
		write_link(CFG_LINK_ONE, 15'd16384);
		write_link(CFG_LINK_TWO, 15'd16384);
		write_link(CFG_LINK_THREE, 15'd16384);
		repeat (20) send_reachable();
		drain_pipe();
		write_link(CFG_LINK_ONE, 15'h7fff);
		write_link(CFG_LINK_TWO, 15'd12000);
		write_link(CFG_LINK_THREE, 15'h7fff);
		repeat (20) send_reachable();
		drain_pipe();
		// uneven arm
		write_link(CFG_LINK_ONE, 15'd3000);
		write_link(CFG_LINK_TWO, 15'd9000);
		write_link(CFG_LINK_THREE, 15'd500);
		repeat (40) send_reachable();
		drain_pipe();
		// spare index leaves every link alone
		write_link(CFG_SPARE, 15'h5555);
		repeat (10) send_reachable();
		drain_pipe();
	endtask

	task automatic test_backpressure();
		// receiver holds off while poses stream in back to back
		steady = 1'b1;
		hold_len <= 600;
		repeat (300) send_reachable();
		steady = 1'b0;
		drain_pipe();
	endtask

	task automatic test_random();
		write_link(CFG_LINK_ONE, 15'd5120);
		write_link(CFG_LINK_TWO, 15'd4096);
		write_link(CFG_LINK_THREE, 15'd1024);
		for (int n = 0; n < 380; n++) begin
			// a stretch with no idling on either side
			steady = (n >= 150 && n < 270);
			if ($urandom_range(0, 99) < 80) send_reachable();
			else send_pose(16'($urandom), 16'($urandom), 16'($urandom));
			if (n == 300) begin
				// new arm mid-run, pipeline emptied first
				drain_pipe();
				write_link(CFG_LINK_ONE, 15'($urandom_range(1, 16384)));
				write_link(CFG_LINK_TWO, 15'($urandom_range(1, 16384)));
				write_link(CFG_LINK_THREE, 15'($urandom_range(0, 16384)));
			end
		end
		steady = 1'b0;
		drain_pipe();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_link_settings();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
